### src/dhh_pkg.sv
// Shared types, codes and calendar tables for the day and hour histogram.
// Used by every module of the histogram core; depends on nothing.
`timescale 1ns / 1ps

package dhh_pkg;

  localparam int DEF_DAY_BINS  = 4096;
  localparam int DEF_BASE_YEAR = 2009;
  localparam int HOUR_BINS     = 24;
  localparam int ADDR_MAX_W    = 16;
  localparam int DATE_W        = 21;
  localparam int CNT_W         = 32;
  localparam int QDEPTH        = 2;
  localparam int RECIP100      = 5243;
  localparam int RECIP100_SH   = 19;

  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_RD_DAY  = 2'd1,
    CMD_RD_HOUR = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_RECORDED = 2'd0,
    STS_INVALID  = 2'd1,
    STS_RANGE    = 2'd2,
    STS_READ     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_REC     = 2'd0,
    K_RD_DAY  = 2'd1,
    K_RD_HOUR = 2'd2,
    K_RESP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_READ  = 2'd2
  } bk_state_t;

  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic [ADDR_MAX_W-1:0] addr;
    logic [11:0]           day_number;
    logic [4:0]            hour;
    logic [DATE_W-1:0]     date;
  } entry_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### src/dhh_front.sv
// Front end: accepts items, checks the date and computes the day number.
// Constant products are registered, then sums and checks follow; depends on dhh_pkg.
`timescale 1ns / 1ps

module dhh_front #(
  parameter int DAY_BINS  = dhh_pkg::DEF_DAY_BINS,
  parameter int BASE_YEAR = dhh_pkg::DEF_BASE_YEAR
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            busy,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_command,
  input  logic [11:0]     in_year,
  input  logic [3:0]      in_month,
  input  logic [4:0]      in_day,
  input  logic [4:0]      in_hour,
  input  logic [11:0]     in_bin_index,
  input  logic            q_full,
  output logic            q_push,
  output dhh_pkg::entry_t q_entry
);
  import dhh_pkg::*;

  localparam int BASE_P    = BASE_YEAR - 1;
  localparam int BASE_DAYS = 365 * BASE_P + BASE_P / 4 - BASE_P / 100 + BASE_P / 400;

  logic        s1_vld_r, s1_vld_nxt;
  cmd_t        cmd_r;
  logic [11:0] year_r, idx_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r, hour_r;
  logic [20:0] p365_r;
  logic [5:0]  qp_r, qy_r;

  logic        accept;
  logic [11:0] p_in, p_w;
  logic [24:0] qp_prod, qy_prod;
  logic        div100, leap, month_ok, hour_ok, day_ok;
  logic [4:0]  mlen;
  logic [21:0] dn;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy || (s1_vld_r && q_full);
  assign q_push   = s1_vld_r && !q_full;

  assign p_in    = in_year - 12'd1;
  assign qp_prod = 25'(p_in) * 25'(RECIP100);
  assign qy_prod = 25'(in_year) * 25'(RECIP100);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (q_push) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
      hour_r  <= in_hour;
      idx_r   <= in_bin_index;
      p365_r  <= 21'(p_in) * 21'd365;
      qp_r    <= qp_prod[RECIP100_SH +: 6];
      qy_r    <= qy_prod[RECIP100_SH +: 6];
    end
  end

  assign p_w      = year_r - 12'd1;
  assign div100   = ((13'(qy_r) * 13'd100) == 13'(year_r));
  assign leap     = (year_r[1:0] == 2'd0 && !div100) || (div100 && qy_r[1:0] == 2'd0);
  assign mlen     = month_len(month_r) + 5'((month_r == 4'd2) && leap);
  assign month_ok = (month_r >= 4'd1) && (month_r <= 4'd12);
  assign hour_ok  = (hour_r < 5'(HOUR_BINS));
  assign day_ok   = (day_r >= 5'd1) && (day_r <= mlen);
  assign dn       = 22'(p365_r) + 22'(p_w[11:2]) - 22'(qp_r) + 22'(qp_r[5:2])
                  - 22'(BASE_DAYS) + 22'(month_start(month_r)) + 22'(day_r) - 22'd1
                  + 22'((month_r > 4'd2) && leap);

  always_comb begin
    q_entry            = '0;
    q_entry.kind       = K_RESP;
    q_entry.status     = STS_RANGE;
    unique case (cmd_r)
      CMD_RECORD: begin
        if (!month_ok || !hour_ok || !day_ok) begin
          q_entry.status = STS_INVALID;
        end else if (year_r < 12'(BASE_YEAR) || dn >= 22'(DAY_BINS)) begin
          q_entry.status = STS_RANGE;
        end else begin
          q_entry.kind       = K_REC;
          q_entry.status     = STS_RECORDED;
          q_entry.addr       = ADDR_MAX_W'(dn);
          q_entry.day_number = dn[11:0];
          q_entry.hour       = hour_r;
          q_entry.date       = {year_r, month_r, day_r};
        end
      end
      CMD_RD_DAY: begin
        if (32'(idx_r) < 32'(DAY_BINS)) begin
          q_entry.kind       = K_RD_DAY;
          q_entry.status     = STS_READ;
          q_entry.addr       = ADDR_MAX_W'(idx_r);
          q_entry.day_number = idx_r;
        end
      end
      CMD_RD_HOUR: begin
        if (idx_r < 12'(HOUR_BINS)) begin
          q_entry.kind   = K_RD_HOUR;
          q_entry.status = STS_READ;
          q_entry.hour   = idx_r[4:0];
        end
      end
      CMD_UNUSED: begin
        q_entry.kind = K_RESP;
      end
      default: begin
        q_entry.kind = K_RESP;
      end
    endcase
  end

endmodule

### src/dhh_queue.sv
// Short queue of classified items between the front end and the back end.
// Depth comes from dhh_pkg.
`timescale 1ns / 1ps

module dhh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dhh_pkg::entry_t push_entry,
  input  logic            pop,
  output dhh_pkg::entry_t head,
  output logic            full,
  output logic            empty
);
  import dhh_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  entry_t        slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/dhh_back.sv
// Back end: day bin memory with clearing pass, hour counters and result register.
// Takes classified items from dhh_queue; depends on dhh_pkg.
`timescale 1ns / 1ps

module dhh_back #(
  parameter int DAY_BINS = dhh_pkg::DEF_DAY_BINS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dhh_pkg::entry_t head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic [11:0]     out_day_number,
  output logic [31:0]     out_count,
  output logic [11:0]     out_stored_year,
  output logic [3:0]      out_stored_month,
  output logic [4:0]      out_stored_day
);
  import dhh_pkg::*;

  localparam int AW    = $clog2(DAY_BINS);
  localparam int MEM_W = DATE_W + CNT_W;

  bk_state_t         state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  entry_t            cur_r;
  logic [MEM_W-1:0]  day_mem [DAY_BINS];
  logic [MEM_W-1:0]  rdata_r;
  logic [CNT_W-1:0]  hour_cnt_r [HOUR_BINS];

  logic              mem_we, mem_re, hour_we, out_load, out_free;
  logic [AW-1:0]     mem_addr;
  logic [MEM_W-1:0]  mem_wdata;
  logic [CNT_W-1:0]  day_cnt_inc, hour_rd, hour_inc;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_nxt;
  logic [11:0]       out_dn_nxt;
  logic [CNT_W-1:0]  out_count_nxt;
  logic [DATE_W-1:0] out_date_nxt;
  logic [1:0]        out_status_r;
  logic [11:0]       out_dn_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [DATE_W-1:0] out_date_r;

  assign out_free    = !out_valid_r || !out_stall;
  assign clearing    = (state_r == BK_CLEAR);
  assign day_cnt_inc = (&rdata_r[CNT_W-1:0]) ? rdata_r[CNT_W-1:0]
                                             : rdata_r[CNT_W-1:0] + CNT_W'(1);
  assign hour_rd     = hour_cnt_r[cur_r.hour];
  assign hour_inc    = (&hour_rd) ? hour_rd : hour_rd + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      BK_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DAY_BINS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty && out_free && head.kind != K_RESP) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = clr_cnt_r;
    mem_wdata      = '0;
    hour_we        = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = STS_RANGE;
    out_dn_nxt     = '0;
    out_count_nxt  = '0;
    out_date_nxt   = '0;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we = 1'b1;
      end
      BK_IDLE: begin
        q_pop    = !q_empty && out_free;
        mem_addr = AW'(head.addr);
        mem_re   = q_pop && head.kind != K_RESP;
        if (q_pop && head.kind == K_RESP) begin
          out_load       = 1'b1;
          out_status_nxt = head.status;
        end
      end
      BK_READ: begin
        mem_addr       = AW'(cur_r.addr);
        out_load       = 1'b1;
        out_status_nxt = cur_r.status;
        unique case (cur_r.kind)
          K_REC: begin
            mem_we        = 1'b1;
            mem_wdata     = {cur_r.date, day_cnt_inc};
            hour_we       = 1'b1;
            out_dn_nxt    = cur_r.day_number;
            out_count_nxt = day_cnt_inc;
          end
          K_RD_DAY: begin
            out_dn_nxt    = cur_r.day_number;
            out_count_nxt = rdata_r[CNT_W-1:0];
            out_date_nxt  = rdata_r[MEM_W-1:CNT_W];
          end
          K_RD_HOUR: begin
            out_count_nxt = hour_rd;
          end
          default: begin
            out_count_nxt = '0;
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      day_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= day_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HOUR_BINS; i++) begin
        hour_cnt_r[i] <= '0;
      end
    end else if (hour_we) begin
      hour_cnt_r[cur_r.hour] <= hour_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= head;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_dn_r     <= out_dn_nxt;
      out_count_r  <= out_count_nxt;
      out_date_r   <= out_date_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_day_number   = out_dn_r;
  assign out_count        = out_count_r;
  assign out_stored_year  = out_date_r[DATE_W-1:9];
  assign out_stored_month = out_date_r[8:5];
  assign out_stored_day   = out_date_r[4:0];

endmodule

### src/date_day_hour_histogram_core.sv
// Top level of the day and hour event histogram with Gregorian date checks.
// Instantiates dhh_front, dhh_queue and dhh_back; depends on dhh_pkg.
//
//   Channel  Ports                          Direction  Handshake
//   input    in_command .. in_bin_index     in         in_valid / in_stall
//   result   out_status .. out_stored_day   out        out_valid / out_stall
//
// An item is registered once in the front end, then waits in a two-entry queue.
// The back end handles each record or read command as a registered memory
// read, then write and result, as the day bin memory has a single port;
// an item rejected up front is answered from the idle state with no read.
// After reset a clearing pass zeroes every day bin, and in_stall stays high
// during it. A stalled result holds while new items queue.
`timescale 1ns / 1ps

module date_day_hour_histogram_core #(
  parameter int DAY_BINS  = dhh_pkg::DEF_DAY_BINS,
  parameter int BASE_YEAR = dhh_pkg::DEF_BASE_YEAR
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [11:0] in_bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_day_number,
  output logic [31:0] out_count,
  output logic [11:0] out_stored_year,
  output logic [3:0]  out_stored_month,
  output logic [4:0]  out_stored_day
);
  import dhh_pkg::*;

  entry_t push_entry, head;
  logic   q_push, q_pop, q_full, q_empty, bk_clearing;

  dhh_front #(
    .DAY_BINS  (DAY_BINS),
    .BASE_YEAR (BASE_YEAR)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (bk_clearing),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .in_hour      (in_hour),
    .in_bin_index (in_bin_index),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  dhh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  dhh_back #(
    .DAY_BINS (DAY_BINS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .clearing         (bk_clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_day_number   (out_day_number),
    .out_count        (out_count),
    .out_stored_year  (out_stored_year),
    .out_stored_month (out_stored_month),
    .out_stored_day   (out_stored_day)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_clearing |-> in_stall)
    else $error("item accepted during clearing pass");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_clearing)
    else $error("queue popped during clearing pass");

  a_record_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_RECORDED) |-> (out_count != '0))
    else $error("recorded event returned a zero count");

endmodule
